[src/aswt_pkg.sv]
// ---------------------------------------------------------------------------
// aswt_pkg
// types and constants shared by the sliding window trigger files
// ---------------------------------------------------------------------------
package aswt_pkg;

  typedef struct packed {
    logic [63:0] tp_time;
    logic [31:0] tp_adc_sum;
    logic [15:0] tp_peak_amp;
    logic [31:0] tp_channel;
    logic [15:0] tp_samples_over;
    logic [15:0] tp_samples_to_peak;
    logic [15:0] tp_detector;
  } tp_t;

  typedef struct packed {
    logic [63:0] ta_t_first;
    logic [63:0] ta_t_last;
    logic [63:0] ta_t_max;
    logic [31:0] ta_ch_low;
    logic [31:0] ta_ch_high;
    logic [31:0] ta_ch_max;
    logic [47:0] ta_adc_sum;
    logic [15:0] ta_peak_amp;
    logic [15:0] ta_detector;
    logic [8:0]  ta_count;
  } ta_t;

  // stored hit: time, adc, channel, to_peak, over, peak
  localparam int unsigned HIT_W = 64 + 32 + 32 + 48;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SCALE     = 2'd2;

endpackage

[src/adc_sliding_window_trigger_unit.sv]
// ---------------------------------------------------------------------------
// adc_sliding_window_trigger_unit
// sliding window adc sum trigger over time ordered detector hits
// ---------------------------------------------------------------------------
// One hit at a time. A hit that joins the window or restarts it passes
// through decode and push; joining a full window first reads back and drops
// the oldest hit. A hit that slides the window reads and time-compares
// stored hits from the oldest on, evicting each one that has left the window
// (one memory read and one time compare for each hit examined), until one
// stays or the whole window is evicted, then pushes. A trigger walks every
// stored hit, newest first and then oldest onwards, through one multiplier,
// adder and compare stage before the window restarts. The single read port
// of the hit store serialises these steps. The result sits in an output
// register, so the next hit is taken while it waits; a further trigger waits
// in decode until it has been taken.
module adc_sliding_window_trigger_unit
  import aswt_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tp_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ta_t         out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(WINDOW_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_EVRD  = 4'd2;
  localparam logic [3:0] S_EVCMP = 4'd3;
  localparam logic [3:0] S_FLRD  = 4'd4;
  localparam logic [3:0] S_FLGET = 4'd5;
  localparam logic [3:0] S_PUSH  = 4'd6;
  localparam logic [3:0] S_ARD   = 4'd7;
  localparam logic [3:0] S_AGET  = 4'd8;
  localparam logic [3:0] S_AMUL  = 4'd9;
  localparam logic [3:0] S_AACC  = 4'd10;
  localparam logic [3:0] S_AOUT  = 4'd11;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] win_r;
  logic [47:0] thr_r;
  logic [7:0]  scl_r;

  tp_t         hit_r;
  logic [AW-1:0] oldest_r;
  logic [CW-1:0] count_r;
  logic [63:0] begin_r;
  logic [47:0] total_r;
  logic [15:0] det_r;
  logic [CW-1:0] idx_r;
  logic        first_r;

  logic [63:0] t_min_r, t_max_r, t_pk_r, te_r;
  logic [31:0] ch_min_r, ch_max_r, ch_pk_r;
  logic [15:0] pk_r;

  ta_t  out_r;
  logic out_valid_r;

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [HIT_W-1:0] wdata, rdata;
  logic [63:0] r_time;
  logic [31:0] r_adc, r_ch;
  logic [15:0] r_tpk, r_over, r_peak;

  // slot sums stay below twice the depth
  function automatic logic [AW-1:0] slot_wrap(input logic [CW:0] s);
    if (s >= (CW+1)'(WINDOW_DEPTH)) return AW'(s - (CW+1)'(WINDOW_DEPTH));
    else return AW'(s);
  endfunction

  assign {r_time, r_adc, r_ch, r_tpk, r_over, r_peak} = rdata;

  aswt_ram #(.WIDTH(HIT_W), .DEPTH(WINDOW_DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign wdata = {hit_r.tp_time, hit_r.tp_adc_sum, hit_r.tp_channel,
                  hit_r.tp_samples_to_peak, hit_r.tp_samples_over, hit_r.tp_peak_amp};
  assign waddr = slot_wrap((CW+1)'(oldest_r) + (CW+1)'(count_r));
  assign we    = (state_r == S_PUSH);

  logic [CW-1:0] rd_off;
  logic          walk;
  assign walk = (state_r == S_ARD) || (state_r == S_AGET) || (state_r == S_AMUL);
  always_comb begin
    rd_off = idx_r;
    // the newest hit seeds the trigger walk, then oldest onwards
    if (walk) rd_off = (idx_r == '0) ? count_r - CW'(1) : idx_r - CW'(1);
  end
  assign raddr = slot_wrap((CW+1)'(oldest_r) + (CW+1)'(rd_off));

  // shared 32-bit product, and the 64-bit time since a stored hit
  logic [31:0] mul_q;
  logic [63:0] since;
  assign since = hit_r.tp_time - r_time;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_WINDOW:    cfg_prdata = {32'd0, win_r};
      REG_THRESHOLD: cfg_prdata = {16'd0, thr_r};
      REG_SCALE:     cfg_prdata = {56'd0, scl_r};
      default:       cfg_prdata = 64'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        if (count_r == '0) state_nxt = S_PUSH;
        else if (hit_r.tp_time - begin_r < {32'd0, win_r}) begin
          state_nxt = (count_r == FULL) ? S_FLRD : S_PUSH;
        end else if (total_r > thr_r) begin
          state_nxt = out_valid_r ? S_DEC : S_ARD;
        end else state_nxt = S_EVRD;
      end
      S_EVRD:  state_nxt = S_EVCMP;
      S_EVCMP: begin
        if (since >= {32'd0, win_r}) state_nxt = (count_r == CW'(1)) ? S_PUSH : S_EVRD;
        else state_nxt = S_PUSH;
      end
      S_FLRD:  state_nxt = S_FLGET;
      S_FLGET: state_nxt = S_PUSH;
      S_PUSH:  state_nxt = S_IDLE;
      S_ARD:   state_nxt = S_AGET;
      S_AGET:  state_nxt = S_AMUL;
      S_AMUL:  state_nxt = S_AACC;
      S_AACC:  state_nxt = (idx_r + CW'(1) == count_r) ? S_AOUT : S_ARD;
      S_AOUT:  state_nxt = S_PUSH;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= 32'd64000;
      thr_r       <= 48'd10000;
      scl_r       <= 8'd32;
      oldest_r    <= '0;
      count_r     <= '0;
      begin_r     <= '0;
      total_r     <= '0;
      det_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      first_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[4:3])
          REG_WINDOW:    win_r <= cfg_pwdata[31:0];
          REG_THRESHOLD: thr_r <= cfg_pwdata[47:0];
          REG_SCALE:     scl_r <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) hit_r <= in_data;
        S_DEC: begin
          idx_r <= '0;
          first_r <= 1'b1;
          if (count_r == '0) begin
            count_r <= '0; oldest_r <= '0; total_r <= '0;
            begin_r <= hit_r.tp_time;
          end
        end
        S_EVRD: ;
        S_EVCMP: begin
          if (since >= {32'd0, win_r}) begin
            count_r <= count_r - CW'(1);
            if (count_r == CW'(1)) begin
              oldest_r <= '0; total_r <= '0; begin_r <= hit_r.tp_time;
            end else begin
              total_r  <= total_r - 48'(r_adc);
              oldest_r <= slot_wrap((CW+1)'(oldest_r) + (CW+1)'(1));
            end
          end else begin
            begin_r <= r_time;
          end
        end
        S_FLRD: begin
          // next oldest is read from here on, its time becomes the window start
          idx_r   <= CW'(1);
          first_r <= 1'b0;
        end
        S_FLGET: begin
          total_r  <= total_r - 48'(r_adc);
          oldest_r <= slot_wrap((CW+1)'(oldest_r) + (CW+1)'(1));
          count_r  <= count_r - CW'(1);
        end
        S_PUSH: begin
          total_r <= total_r + 48'(hit_r.tp_adc_sum);
          det_r   <= hit_r.tp_detector;
          count_r <= count_r + CW'(1);
          if (idx_r == CW'(1) && !first_r) begin
            begin_r <= r_time;
          end
        end
        S_ARD: ;
        S_AGET: begin
          mul_q <= 32'(r_over) * 32'(scl_r);
        end
        S_AMUL: begin
          te_r  <= r_time + 64'(mul_q);
          mul_q <= 32'(r_tpk) * 32'(scl_r);
        end
        S_AACC: begin
          idx_r   <= idx_r + CW'(1);
          first_r <= 1'b0;
          if (first_r || r_ch < ch_min_r) ch_min_r <= r_ch;
          if (first_r || r_ch > ch_max_r) ch_max_r <= r_ch;
          if (first_r || r_time < t_min_r) t_min_r <= r_time;
          if (first_r || te_r > t_max_r) t_max_r <= te_r;
          if (first_r || r_peak > pk_r) begin
            pk_r <= r_peak; ch_pk_r <= r_ch; t_pk_r <= r_time + 64'(mul_q);
          end
        end
        S_AOUT: begin
          out_r.ta_t_first  <= t_min_r;
          out_r.ta_t_last   <= t_max_r;
          out_r.ta_t_max    <= t_pk_r;
          out_r.ta_ch_low   <= ch_min_r;
          out_r.ta_ch_high  <= ch_max_r;
          out_r.ta_ch_max   <= ch_pk_r;
          out_r.ta_adc_sum  <= total_r;
          out_r.ta_peak_amp <= pk_r;
          out_r.ta_detector <= det_r;
          out_r.ta_count    <= 9'(count_r);
          out_valid_r <= 1'b1;
          count_r <= '0; oldest_r <= '0; total_r <= '0;
          begin_r <= hit_r.tp_time;
          idx_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  logic unused;
  assign unused = ^{cfg_pwdata[63:48], cfg_paddr[2:0]};

endmodule

[src/aswt_ram.sv]
// ---------------------------------------------------------------------------
// aswt_ram
// single port write, single port registered read memory
// ---------------------------------------------------------------------------
module aswt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/aswt_checker.sv]
// ---------------------------------------------------------------------------
// aswt_checker
// port level checks for the sliding window trigger
// ---------------------------------------------------------------------------
module aswt_checker
  import aswt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input ta_t  out_data,
  input logic cfg_pready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");

  // a window never reports an empty count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ta_count != 9'd0) else $error("zero count");

  // an accepted hit keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("not busy");

  a_ready: assert property (@(posedge clk) cfg_pready) else $error("pready low");

endmodule

bind adc_sliding_window_trigger_unit aswt_checker u_aswt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_pready(cfg_pready)
);

[test/adc_sliding_window_trigger_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// adc_sliding_window_trigger_unit_checker
// watches the hit, activity and register ports, predicts every activity from
// its own copy of the hit window and compares it with what the block emits
// ---------------------------------------------------------------------------
module adc_sliding_window_trigger_unit_checker
  import aswt_pkg::*;
#(
  parameter int unsigned     DEPTH         = 256,
  parameter logic [4:0]      ADDR_WINDOW   = 5'd0,
  parameter logic [4:0]      ADDR_THRESH   = 5'd8,
  parameter logic [4:0]      ADDR_SCALE    = 5'd16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  tp_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  ta_t         out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output int          errors,
  output int          pending,
  output int          activities
);

  // predictor state
  logic [31:0] win_ticks;
  logic [47:0] adc_thresh;
  logic [7:0]  tick_scale;
  tp_t         window_hits[$];
  logic [63:0] win_begin;
  logic [47:0] win_total;
  logic [15:0] last_detector;
  ta_t         activity_q[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic drop_front();
    win_total -= window_hits[0].tp_adc_sum;
    void'(window_hits.pop_front());
  endtask

  task automatic add_hit(input tp_t h);
    if (window_hits.size() >= DEPTH) begin
      drop_front();
      win_begin = window_hits[0].tp_time;
    end
    window_hits.insert(window_hits.size(), h);
    win_total += h.tp_adc_sum;
    last_detector = h.tp_detector;
  endtask

  task automatic restart_window(input tp_t h);
    window_hits.delete();
    win_total = '0;
    win_begin = h.tp_time;
    add_hit(h);
  endtask

  function automatic ta_t summarise_window();
    ta_t a;
    tp_t h;
    logic [63:0] te;
    h = window_hits[window_hits.size() - 1];
    a.ta_t_first  = h.tp_time;
    a.ta_t_last   = h.tp_time + 64'(h.tp_samples_over) * 64'(tick_scale);
    a.ta_t_max    = h.tp_time + 64'(h.tp_samples_to_peak) * 64'(tick_scale);
    a.ta_ch_low   = h.tp_channel;
    a.ta_ch_high  = h.tp_channel;
    a.ta_ch_max   = h.tp_channel;
    a.ta_peak_amp = h.tp_peak_amp;
    foreach (window_hits[i]) begin
      h = window_hits[i];
      te = h.tp_time + 64'(h.tp_samples_over) * 64'(tick_scale);
      if (h.tp_channel < a.ta_ch_low) a.ta_ch_low = h.tp_channel;
      if (h.tp_channel > a.ta_ch_high) a.ta_ch_high = h.tp_channel;
      if (h.tp_time < a.ta_t_first) a.ta_t_first = h.tp_time;
      if (te > a.ta_t_last) a.ta_t_last = te;
      // strictly larger only, so the newest hit keeps ties
      if (h.tp_peak_amp > a.ta_peak_amp) begin
        a.ta_peak_amp = h.tp_peak_amp;
        a.ta_ch_max   = h.tp_channel;
        a.ta_t_max    = h.tp_time + 64'(h.tp_samples_to_peak) * 64'(tick_scale);
      end
    end
    a.ta_adc_sum  = win_total;
    a.ta_detector = last_detector;
    a.ta_count    = 9'(window_hits.size());
    return a;
  endfunction

  task automatic take_hit(input tp_t h);
    if (window_hits.size() == 0) begin
      restart_window(h);
    end else if (h.tp_time - win_begin < {32'd0, win_ticks}) begin
      add_hit(h);
    end else if (win_total > adc_thresh) begin
      activity_q.insert(activity_q.size(), summarise_window());
      restart_window(h);
    end else begin
      while (window_hits.size() > 0 &&
             h.tp_time - window_hits[0].tp_time >= {32'd0, win_ticks})
        drop_front();
      if (window_hits.size() == 0) begin
        restart_window(h);
      end else begin
        win_begin = window_hits[0].tp_time;
        add_hit(h);
      end
    end
  endtask

  task automatic check_activity(input ta_t got);
    ta_t want;
    if (activity_q.size() == 0) begin
      report("unexpected activity", got.ta_t_first, '0);
    end else begin
      want = activity_q.pop_front();
      if (got.ta_t_first != want.ta_t_first)
        report("first time", got.ta_t_first, want.ta_t_first);
      if (got.ta_t_last != want.ta_t_last)
        report("last time", got.ta_t_last, want.ta_t_last);
      if (got.ta_t_max != want.ta_t_max)
        report("peak time", got.ta_t_max, want.ta_t_max);
      if (got.ta_ch_low != want.ta_ch_low)
        report("low channel", 64'(got.ta_ch_low), 64'(want.ta_ch_low));
      if (got.ta_ch_high != want.ta_ch_high)
        report("high channel", 64'(got.ta_ch_high), 64'(want.ta_ch_high));
      if (got.ta_ch_max != want.ta_ch_max)
        report("peak channel", 64'(got.ta_ch_max), 64'(want.ta_ch_max));
      if (got.ta_adc_sum != want.ta_adc_sum)
        report("adc_sum", 64'(got.ta_adc_sum), 64'(want.ta_adc_sum));
      if (got.ta_peak_amp != want.ta_peak_amp)
        report("peak amplitude", 64'(got.ta_peak_amp), 64'(want.ta_peak_amp));
      if (got.ta_detector != want.ta_detector)
        report("detector", 64'(got.ta_detector), 64'(want.ta_detector));
      if (got.ta_count != want.ta_count)
        report("count", 64'(got.ta_count), 64'(want.ta_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_ticks     = 32'd64000;
      adc_thresh    = 48'd10000;
      tick_scale    = 8'd32;
      win_begin     = '0;
      win_total     = '0;
      last_detector = '0;
      window_hits.delete();
      activity_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_WINDOW: begin
            win_ticks = cfg_pwdata[31:0];
          end
          ADDR_THRESH: begin
            adc_thresh = cfg_pwdata[47:0];
          end
          ADDR_SCALE: begin
            tick_scale = cfg_pwdata[7:0];
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        check_activity(out_data);
        activities++;
      end
      if (in_valid && !in_stall) take_hit(in_data);
    end
    pending = activity_q.size();
  end

endmodule

[test/adc_sliding_window_trigger_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// adc_sliding_window_trigger_unit_tb
// drives hit streams through the sliding window trigger under a range of
// register settings, with random idling on both sides; the checker beside
// the block predicts and compares every activity
// ---------------------------------------------------------------------------
module adc_sliding_window_trigger_unit_tb;
  import aswt_pkg::*;

  localparam logic [4:0] ADDR_WINDOW = 5'd0;
  localparam logic [4:0] ADDR_THRESH = 5'd8;
  localparam logic [4:0] ADDR_SCALE  = 5'd16;
  localparam int         SETTLE      = 20;
  localparam int         STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tp_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ta_t         out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int          errors;
  int          pending;
  int          activities;
  int          hits_sent = 0;
  int          idle_count = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;
  logic [63:0] hit_clock;

  always #5 clk = ~clk;

  adc_sliding_window_trigger_unit DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready
  );

  adc_sliding_window_trigger_unit_checker #(
    .ADDR_WINDOW(ADDR_WINDOW), .ADDR_THRESH(ADDR_THRESH), .ADDR_SCALE(ADDR_SCALE)
  ) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .errors, .pending, .activities
  );

  // activity side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic write_reg(input logic [4:0] addr, input logic [63:0] value);
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // wait for every predicted activity and for the block to go idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || in_stall);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] ticks, input logic [47:0] thresh,
                            input logic [7:0] scale);
    drain();
    write_reg(ADDR_WINDOW, {32'd0, ticks});
    write_reg(ADDR_THRESH, {16'd0, thresh});
    write_reg(ADDR_SCALE, {56'd0, scale});
  endtask

  task automatic send_hit(input tp_t h);
    in_data  <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    hits_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic tp_t make_hit(input logic [63:0] t, input logic [31:0] adc,
                                   input logic [15:0] peak, input logic [31:0] chan);
    tp_t h;
    h.tp_time            = t;
    h.tp_adc_sum         = adc;
    h.tp_peak_amp        = peak;
    h.tp_channel         = chan;
    h.tp_samples_over    = 16'($urandom);
    h.tp_samples_to_peak = 16'($urandom);
    h.tp_detector        = 16'($urandom);
    return h;
  endfunction

  // mostly ordered hits with random content, some out of order jumps
  task automatic random_hits(input int n, input int step_max, input int adc_max);
    tp_t h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        hit_clock = {$urandom, $urandom};
      else
        hit_clock += 64'($urandom_range(0, step_max));
      h = make_hit(hit_clock, $urandom_range(0, adc_max), 16'($urandom), $urandom);
      if ($urandom_range(0, 9) == 0) h.tp_adc_sum = $urandom;
      send_hit(h);
    end
  endtask

  initial begin
    tp_t h;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrap of time, extreme fields, tied peaks, slide and restart
    set_window(32'd100, 48'd1000, 8'd255);
    h = make_hit(64'hFFFF_FFFF_FFFF_FFCE, 32'd600, 16'hFFFF, 32'hFFFF_FFFF);
    h.tp_samples_over    = 16'hFFFF;
    h.tp_samples_to_peak = 16'hFFFF;
    h.tp_detector        = 16'hFFFF;
    send_hit(h);
    send_hit(make_hit(64'hFFFF_FFFF_FFFF_FFF6, 32'd500, 16'hFFFF, 32'd0));
    h = make_hit(64'd20, 32'd0, 16'd0, 32'd7);
    h.tp_samples_over    = 16'd0;
    h.tp_samples_to_peak = 16'd0;
    h.tp_detector        = 16'd0;
    send_hit(h);
    send_hit(make_hit(64'd60, 32'd5, 16'd3, 32'd9));
    send_hit(make_hit(64'd200, 32'd10, 16'd1, 32'd4));
    send_hit(make_hit(64'd250, 32'd10, 16'd2, 32'd5));
    send_hit(make_hit(64'd320, 32'd10, 16'd2, 32'd5));
    send_hit(make_hit(64'd350, 32'd10, 16'd2, 32'd6));
    send_hit(make_hit(64'd400, 32'hFFFF_FFFF, 16'd9, 32'd1));
    send_hit(make_hit(64'd401, 32'hFFFF_FFFF, 16'd9, 32'd2));
    send_hit(make_hit(64'd600, 32'd1, 16'd0, 32'd3));
    // zero window and zero threshold: every hit with adc but the last fires alone
    set_window(32'd0, 48'd0, 8'd0);
    for (int i = 0; i < 5; i++)
      send_hit(make_hit(64'd1000 + 64'(i), 32'(i), 16'($urandom), $urandom));
    // full store: nothing fires until the threshold drops
    set_window(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd1);
    hit_clock = {$urandom, $urandom};
    for (int i = 0; i < 270; i++) begin
      hit_clock += 64'($urandom_range(0, 3));
      send_hit(make_hit(hit_clock, $urandom, 16'($urandom), $urandom));
    end
    set_window(32'd0, 48'd0, 8'd255);
    send_hit(make_hit(hit_clock + 64'h1_0000_0000, 32'd1, 16'd0, 32'd0));

    // random phases over a spread of settings
    set_window(32'd1000, 48'd20000, 8'd32);
    random_hits(80, 200, 4000);
    set_window(32'd64000, 48'd10000, 8'd32);
    random_hits(80, 20000, 3000);
    set_window(32'd50, 48'h7FFF_FFFF, 8'd200);
    random_hits(60, 30, 32'hFFFF_FFFF);
    set_window(32'($urandom_range(10, 5000)), 48'($urandom_range(0, 100000)),
               8'($urandom_range(1, 255)));
    random_hits(80, 1000, 10000);
    set_window(32'd3000, 48'd0, 8'd7);
    random_hits(60, 800, 100);
    set_window(32'd500, 48'd30000, 8'd16);
    quiet = 1'b1;
    random_hits(100, 80, 2000);

    drain();
    $display("sent %0d hits over ten register settings, %0d activities compared",
             hits_sent, activities);
    $display("covered time wrap, full store eviction, tied peaks and zero scale");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
